/* design/lex3_pkg.sv */
// ============================================================================
// lex3_pkg
// Shared types and constants for the 3x3 local extremum detector.
// ============================================================================
package lex3_pkg;

    localparam int CNT_W      = 12;   // internal column counter
    localparam int OUT_COL_W  = 11;
    localparam int ROW_W      = 12;
    localparam int MARGIN_W   = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int OQ_DEPTH   = 4;

    localparam logic [CNT_W-1:0]    RST_WIDTH  = 12'd640;
    localparam logic [ROW_W-1:0]    RST_HEIGHT = 12'd480;
    localparam logic [MARGIN_W-1:0] RST_MARGIN = 8'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MARGIN = 2'd2,
        CFG_MINIMA = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic is_max;
        logic is_min;
    } t_cmp;

endpackage

/* design/local_extremum_3x3_detector.sv */
// ============================================================================
// local_extremum_3x3_detector
// Streaming 3x3 non-maximum suppression with optional minimum reporting.
// ============================================================================
// Takes one sample word per clock in raster order while o_stall is low.
// The two previous rows live in two line-buffer RAMs of MAX_WIDTH words;
// an entry is read when its sample is accepted and written back the next
// cycle, with forwarding when consecutive words hit the same entry. A result
// word passes the s1, window and s2 registers and the output queue. A
// four-word output queue absorbs output stalls; input stall rises only once
// that queue plus the two words in flight could fill it. No clearing pass.
module local_extremum_3x3_detector #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lex3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lex3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic                               i_frame_start,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [lex3_pkg::OUT_COL_W-1:0]     o_column,
    output logic [lex3_pkg::ROW_W-1:0]         o_row,
    output logic signed [SAMPLE_BITS-1:0]      o_strength,
    output logic                               o_is_minimum
);
    import lex3_pkg::*;

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int W_CLAMP = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
    localparam int RES_W   = OUT_COL_W + ROW_W + SAMPLE_BITS + 1;
    localparam int QC_W    = $clog2(OQ_DEPTH+1);

    // configuration
    logic [CNT_W-1:0]    r_width;
    logic [ROW_W-1:0]    r_height;
    logic [MARGIN_W-1:0] r_margin;
    logic                r_find_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_margin   <= RST_MARGIN;
            r_find_min <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width    <= i_cfg_data[CNT_W-1:0];
                CFG_HEIGHT: r_height   <= i_cfg_data[ROW_W-1:0];
                CFG_MARGIN: r_margin   <= i_cfg_data[MARGIN_W-1:0];
                CFG_MINIMA: r_find_min <= i_cfg_data[0];
            endcase
        end
    end

    logic [CNT_W-1:0]    w_eff;
    logic [ROW_W-1:0]    h_eff;
    logic [MARGIN_W-1:0] m_eff;

    always_comb begin
        if (r_width == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_width) > W_CLAMP) begin
            w_eff = CNT_W'(W_CLAMP);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? ROW_W'(1) : r_height;
        m_eff = (r_margin == '0) ? MARGIN_W'(1) : r_margin;
    end

    // acceptance stage: position, border test, line-buffer read
    logic             accept;
    logic [CNT_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] col_cur, cc;
    logic [ROW_W-1:0] row_cur, rr;
    logic [AW-1:0]    idx;
    logic             test;
    logic [CNT_W:0]   col_p1;
    logic [ROW_W:0]   row_p1;

    assign accept = i_valid && !o_stall;

    always_comb begin
        col_cur = i_frame_start ? '0 : r_col;
        row_cur = i_frame_start ? '0 : r_row;
        cc      = col_cur - 1'b1;
        rr      = row_cur - 1'b1;
        idx     = (32'(col_cur) < MAX_WIDTH) ? AW'(col_cur) : '0;
        test    = (col_cur != '0) && (row_cur != '0) && (col_cur < w_eff)
               && (cc >= CNT_W'(m_eff))
               && (({1'b0, cc} + (CNT_W+1)'(m_eff)) < {1'b0, w_eff})
               && (rr >= ROW_W'(m_eff))
               && (({1'b0, rr} + (ROW_W+1)'(m_eff)) < {1'b0, h_eff});
        col_p1  = {1'b0, col_cur} + 1'b1;
        row_p1  = {1'b0, row_cur} + 1'b1;
        if (col_p1 >= {1'b0, w_eff}) begin
            n_col = '0;
            n_row = (row_p1 >= {1'b0, h_eff}) ? '0 : row_p1[ROW_W-1:0];
        end else begin
            n_col = col_p1[CNT_W-1:0];
            n_row = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    logic                          r_s1_valid;
    logic                          r_s1_test;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [AW-1:0]                 r_s1_idx;
    logic [OUT_COL_W-1:0]          r_s1_cc;
    logic [ROW_W-1:0]              r_s1_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_test   <= test;
            r_s1_sample <= i_sample;
            r_s1_idx    <= idx;
            r_s1_cc     <= cc[OUT_COL_W-1:0];
            r_s1_rr     <= rr;
        end
    end

    // line buffers with write-back forwarding
    logic [SAMPLE_BITS-1:0]        older_rd, newer_rd;
    logic signed [SAMPLE_BITS-1:0] older_eff, newer_eff;
    logic                          r_fw_valid;
    logic [AW-1:0]                 r_fw_idx;
    logic signed [SAMPLE_BITS-1:0] r_fw_older, r_fw_newer;
    logic                          fw_hit;

    lex3_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (newer_eff),
        .i_re    (accept),
        .i_raddr (idx),
        .o_rdata (older_rd)
    );

    lex3_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (r_s1_sample),
        .i_re    (accept),
        .i_raddr (idx),
        .o_rdata (newer_rd)
    );

    assign fw_hit    = r_fw_valid && (r_fw_idx == r_s1_idx);
    assign older_eff = fw_hit ? r_fw_older : $signed(older_rd);
    assign newer_eff = fw_hit ? r_fw_newer : $signed(newer_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_idx   <= r_s1_idx;
        r_fw_older <= newer_eff;
        r_fw_newer <= r_s1_sample;
    end

    // window and compare
    t_cmp                          cmp;
    logic signed [SAMPLE_BITS-1:0] centre;

    lex3_win #(.SAMPLE_BITS(SAMPLE_BITS)) u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (r_s1_valid),
        .i_top    (older_eff),
        .i_mid    (newer_eff),
        .i_bot    (r_s1_sample),
        .o_cmp    (cmp),
        .o_centre (centre)
    );

    logic                 r_s2_valid;
    logic [OUT_COL_W-1:0] r_s2_cc;
    logic [ROW_W-1:0]     r_s2_rr;
    logic                 hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_test;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_cc <= r_s1_cc;
        r_s2_rr <= r_s1_rr;
    end

    assign hit = r_s2_valid && (cmp.is_max || (r_find_min && cmp.is_min));

    // output queue
    logic [RES_W-1:0] q_in, q_out;
    logic [QC_W-1:0]  q_count;
    logic [QC_W:0]    q_load;

    assign q_in = {r_s2_cc, r_s2_rr, centre, !cmp.is_max};

    lex3_fifo #(.WIDTH(RES_W), .DEPTH(OQ_DEPTH)) u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (hit),
        .i_data  (q_in),
        .i_pop   (o_valid && !i_stall),
        .o_valid (o_valid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    assign q_load  = (QC_W+1)'(q_count) + (QC_W+1)'(r_s1_valid) + (QC_W+1)'(r_s2_valid);
    assign o_stall = (q_load >= (QC_W+1)'(OQ_DEPTH));

    assign o_column     = q_out[RES_W-1 -: OUT_COL_W];
    assign o_row        = q_out[SAMPLE_BITS+ROW_W:SAMPLE_BITS+1];
    assign o_strength   = $signed(q_out[SAMPLE_BITS:1]);
    assign o_is_minimum = q_out[0];

endmodule

/* design/lex3_ram.sv */
// ============================================================================
// lex3_ram
// Generic single-clock RAM, one write port and one registered read port.
// ============================================================================
module lex3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lex3_win.sv */
// ============================================================================
// lex3_win
// 3x3 window register with strict maximum / minimum test on its centre.
// ============================================================================
module lex3_win #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic signed [SAMPLE_BITS-1:0] i_top,
    input  logic signed [SAMPLE_BITS-1:0] i_mid,
    input  logic signed [SAMPLE_BITS-1:0] i_bot,
    output lex3_pkg::t_cmp                o_cmp,
    output logic signed [SAMPLE_BITS-1:0] o_centre
);
    import lex3_pkg::*;

    // index row*3+col, row 0 oldest, col 2 newest
    logic signed [SAMPLE_BITS-1:0] r_win [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_shift) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3]   <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2] <= i_top;
            r_win[5] <= i_mid;
            r_win[8] <= i_bot;
        end
    end

    always_comb begin
        o_cmp.is_max = 1'b1;
        o_cmp.is_min = 1'b1;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                if (!(r_win[4] > r_win[k])) o_cmp.is_max = 1'b0;
                if (!(r_win[4] < r_win[k])) o_cmp.is_min = 1'b0;
            end
        end
    end

    assign o_centre = r_win[4];

endmodule

/* design/lex3_fifo.sv */
// ============================================================================
// lex3_fifo
// Small result queue decoupling the detector from the output stall.
// ============================================================================
module lex3_fifo #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule
